>>> hdl/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared constants, types and helpers for the trs matrix composer.
// ----------------------------------------------------------------------------
package trs_pkg;

  localparam int CordicSteps = 16;
  localparam logic signed [32:0] CordicGain = 33'sd652032874;
  localparam logic signed [31:0] TrsOne = 32'sd65536;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic signed [17:0] sx;
    logic signed [17:0] cx;
    logic signed [17:0] sy;
    logic signed [17:0] cy;
    logic signed [17:0] sz;
    logic signed [17:0] cz;
  } trs_job_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sh020000000;
      5'd1:  v = 34'sh012E4051E;
      5'd2:  v = 34'sh009FB385B;
      5'd3:  v = 34'sh0051111D4;
      5'd4:  v = 34'sh0028B0D43;
      5'd5:  v = 34'sh00145D7E1;
      5'd6:  v = 34'sh000A2F61E;
      5'd7:  v = 34'sh000517C55;
      5'd8:  v = 34'sh00028BE53;
      5'd9:  v = 34'sh000145F2F;
      5'd10: v = 34'sh0000A2F98;
      5'd11: v = 34'sh0000517CC;
      5'd12: v = 34'sh000028BE6;
      5'd13: v = 34'sh0000145F3;
      5'd14: v = 34'sh00000A2FA;
      5'd15: v = 34'sh00000517D;
      5'd16: v = 34'sh0000028BE;
      5'd17: v = 34'sh00000145F;
      5'd18: v = 34'sh000000A30;
      5'd19: v = 34'sh000000518;
      5'd20: v = 34'sh00000028C;
      5'd21: v = 34'sh000000146;
      5'd22: v = 34'sh0000000A3;
      default: v = 34'sh000000051;
    endcase
    return v;
  endfunction

  // q16.16 product rounded half up
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> hdl/trs_cordic.sv
// ----------------------------------------------------------------------------
// trs_cordic
// Unrolled, pipelined rotation-mode cordic, one step per stage.
// ----------------------------------------------------------------------------
module trs_cordic import trs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [15:0]        angle,
  output logic               out_valid,
  output logic signed [17:0] sin_q,
  output logic signed [17:0] cos_q
);

  logic signed [33:0] x [CordicSteps+1];
  logic signed [33:0] y [CordicSteps+1];
  logic signed [33:0] z [CordicSteps+1];
  logic               neg [CordicSteps+1];
  logic               vld [CordicSteps+1];
  logic [31:0]        za;
  logic               nq;

  assign za = {angle, 16'd0};
  assign nq = (za[31:30] == 2'b01) || (za[31:30] == 2'b10);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      x[0] <= 34'(CordicGain);
      y[0] <= '0;
      z[0] <= 34'(signed'(nq ? za - 32'h80000000 : za));
      neg[0] <= nq;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        neg[i+1] <= neg[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_entry(5'(i));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_entry(5'(i));
        end
      end
    end
  end

  logic signed [33:0] xf, yf, xr, yr;
  assign xf = neg[CordicSteps] ? -x[CordicSteps] : x[CordicSteps];
  assign yf = neg[CordicSteps] ? -y[CordicSteps] : y[CordicSteps];
  assign xr = (xf + 34'sd8192) >>> 14;
  assign yr = (yf + 34'sd8192) >>> 14;

  function automatic logic signed [17:0] clamp1(input logic signed [33:0] v);
    logic signed [17:0] r;
    if (v > 34'sd65536) r = 18'sd65536;
    else if (v < -34'sd65536) r = -18'sd65536;
    else r = v[17:0];
    return r;
  endfunction

  assign out_valid = vld[CordicSteps];
  assign cos_q = clamp1(xr);
  assign sin_q = clamp1(yr);

endmodule

>>> hdl/trs_front.sv
// ----------------------------------------------------------------------------
// trs_front
// Accepts items, runs three cordics, queues finished jobs for the back end.
// ----------------------------------------------------------------------------
module trs_front import trs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  input  logic [15:0]        angle_x,
  input  logic [15:0]        angle_y,
  input  logic [15:0]        angle_z,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] shift_z,
  output logic               job_valid,
  input  logic               job_take,
  output trs_job_t           job
);

  localparam int Lat = CordicSteps + 1;
  localparam int QDepth = Lat + 4;
  localparam int QW = $clog2(QDepth);
  localparam int CW = $clog2(QDepth + 1);

  logic signed [31:0] dsc [Lat][6];
  logic               en, acc;
  logic               vx, vy, vz;
  logic signed [17:0] sx, cx, sy, cy, sz, cz;
  trs_job_t           q [QDepth];
  logic [QW-1:0]      wp, rp;
  logic [CW-1:0]      cnt, inflight;

  // credit: queue slots plus items still in the cordic pipe
  assign en = 1'b1;
  assign full = (CW'(cnt) + inflight) >= CW'(QDepth);
  assign acc = push && !full;

  trs_cordic u_cx (.clk, .rst, .en, .in_valid(acc), .angle(angle_x),
                   .out_valid(vx), .sin_q(sx), .cos_q(cx));
  trs_cordic u_cy (.clk, .rst, .en, .in_valid(acc), .angle(angle_y),
                   .out_valid(vy), .sin_q(sy), .cos_q(cy));
  trs_cordic u_cz (.clk, .rst, .en, .in_valid(acc), .angle(angle_z),
                   .out_valid(vz), .sin_q(sz), .cos_q(cz));

  always_ff @(posedge clk) begin
    dsc[0][0] <= scale_x; dsc[0][1] <= scale_y; dsc[0][2] <= scale_z;
    dsc[0][3] <= shift_x; dsc[0][4] <= shift_y; dsc[0][5] <= shift_z;
    for (int i = 1; i < Lat; i++) dsc[i] <= dsc[i-1];
  end

  logic pop_q, push_q;
  assign push_q = vx && vy && vz;
  assign pop_q = job_take && job_valid;
  assign job_valid = cnt != '0;
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; inflight <= '0;
    end else begin
      if (push_q) wp <= (wp == QW'(QDepth - 1)) ? '0 : wp + 1'b1;
      if (pop_q) rp <= (rp == QW'(QDepth - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + CW'(push_q) - CW'(pop_q);
      inflight <= inflight + CW'(acc) - CW'(push_q);
    end
    if (push_q) begin
      q[wp] <= '{scale_x: dsc[Lat-1][0], scale_y: dsc[Lat-1][1],
                 scale_z: dsc[Lat-1][2], shift_x: dsc[Lat-1][3],
                 shift_y: dsc[Lat-1][4], shift_z: dsc[Lat-1][5],
                 sx: sx, cx: cx, sy: sy, cy: cy, sz: sz, cz: cz};
    end
  end

endmodule

>>> hdl/trs_back.sv
// ----------------------------------------------------------------------------
// trs_back
// Per row: rotation row in two product stages, scale, then row output queue.
// ----------------------------------------------------------------------------
module trs_back import trs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_take,
  input  trs_job_t           job,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               last_row
);

  localparam int OutDepth = 8;

  typedef struct packed {
    logic [1:0]         row;
    logic signed [31:0] c0, c1, c2, c3;
  } row_t;

  logic [1:0] row;
  logic       issue;
  logic [3:0] ocnt, pend;
  logic       ov;

  // row sequencer, one row a beat while a job is queued and the output queue has room
  assign issue = job_valid && ((ocnt + pend) < 4'(OutDepth - 1));
  assign job_take = issue && (row == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) row <= '0;
    else if (issue) row <= row + 1'b1;
  end

  // stage 1: zy row = rz row * ry, rounded
  logic signed [17:0] rza0, rza1;
  logic signed [63:0] zy0, zy1, zy2;
  always_comb begin
    unique case (row)
      2'd0: begin rza0 = job.cz; rza1 = -job.sz; end
      2'd1: begin rza0 = job.sz; rza1 = job.cz; end
      default: begin rza0 = '0; rza1 = '0; end
    endcase
  end

  // products of two unit-range terms stay within +-1.0
  logic signed [17:0] s1_zy0, s1_zy1, s1_zy2;
  logic [1:0]   s1_row;
  logic         s1_v;
  trs_job_t     s1_job;
  always_comb begin
    zy0 = rnd16(64'(rza0) * 64'(job.cy));
    zy1 = rnd16(64'(rza1) * 64'sd65536);
    zy2 = rnd16(64'(rza0) * 64'(-job.sy));
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else s1_v <= issue;
    s1_row <= row;
    s1_job <= job;
    if (row == 2'd2) begin
      s1_zy0 <= 18'(rnd16(64'(job.sy) * 64'sd65536));
      s1_zy1 <= '0;
      s1_zy2 <= 18'(rnd16(64'(job.cy) * 64'sd65536));
    end else begin
      s1_zy0 <= 18'(zy0); s1_zy1 <= 18'(zy1); s1_zy2 <= 18'(zy2);
    end
  end

  // stage 2: rot row = zy row * rx, sums of two terms stay within +-2.0
  logic signed [18:0] r0, r1, r2;
  logic [1:0]  s2_row;
  logic        s2_v;
  trs_job_t    s2_job;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else s2_v <= s1_v;
    s2_row <= s1_row;
    s2_job <= s1_job;
    r0 <= 19'(rnd16(64'(s1_zy0) * 64'sd65536));
    r1 <= 19'(rnd16(64'(s1_zy1) * 64'(s1_job.cx) + 64'(s1_zy2) * 64'(s1_job.sx)));
    r2 <= 19'(rnd16(64'(s1_zy1) * 64'(-s1_job.sx) + 64'(s1_zy2) * 64'(s1_job.cx)));
  end

  // stage 3: scale and saturate, shift column; row 3 is the constant 0,0,0,1
  row_t s3;
  logic s3_v;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else s3_v <= s2_v;
    s3.row <= s2_row;
    if (s2_row == 2'd3) begin
      s3.c0 <= '0; s3.c1 <= '0; s3.c2 <= '0; s3.c3 <= TrsOne;
    end else begin
      s3.c0 <= sat32(rnd16(64'(r0) * 64'(s2_job.scale_x)));
      s3.c1 <= sat32(rnd16(64'(r1) * 64'(s2_job.scale_y)));
      s3.c2 <= sat32(rnd16(64'(r2) * 64'(s2_job.scale_z)));
      unique case (s2_row)
        2'd0: s3.c3 <= s2_job.shift_x;
        2'd1: s3.c3 <= s2_job.shift_y;
        default: s3.c3 <= s2_job.shift_z;
      endcase
    end
  end

  // output queue
  row_t       oq [OutDepth];
  logic [2:0] owp, orp;
  logic       opop;
  assign ov = ocnt != '0;
  assign empty = !ov;
  assign opop = pop && ov;
  assign row_index = oq[orp].row;
  assign col0 = oq[orp].c0;
  assign col1 = oq[orp].c1;
  assign col2 = oq[orp].c2;
  assign col3 = oq[orp].c3;
  assign last_row = oq[orp].row == 2'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= '0; orp <= '0; ocnt <= '0; pend <= '0;
    end else begin
      if (s3_v) owp <= owp + 1'b1;
      if (opop) orp <= orp + 1'b1;
      ocnt <= ocnt + 4'(s3_v) - 4'(opop);
      pend <= pend + 4'(issue) - 4'(s3_v);
    end
    if (s3_v) oq[owp] <= s3;
  end

endmodule

>>> hdl/euler_trs_matrix_compose_core.sv
// ----------------------------------------------------------------------------
// euler_trs_matrix_compose_core
// Builds the 4x4 T*R*S model matrix from scales, euler angles and a shift.
// ----------------------------------------------------------------------------
// Each accepted item yields four row beats, row 0 first, row 3 being 0,0,0,1.
// The row sequencer issues one row per cycle while a job is queued and the
// output queue has room; path: 17-stage cordic pipeline, job queue, three
// product stages, output queue.
module euler_trs_matrix_compose_core import trs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  input  logic [15:0]        angle_x,
  input  logic [15:0]        angle_y,
  input  logic [15:0]        angle_z,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] shift_z,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               last_row
);

  logic     job_valid, job_take;
  trs_job_t job;

  trs_front u_front (.clk, .rst, .push, .full, .scale_x, .scale_y, .scale_z,
                     .angle_x, .angle_y, .angle_z, .shift_x, .shift_y, .shift_z,
                     .job_valid, .job_take, .job);

  trs_back u_back (.clk, .rst, .job_valid, .job_take, .job, .empty, .pop,
                   .row_index, .col0, .col1, .col2, .col3, .last_row);

endmodule

>>> hdl/trs_checker.sv
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks on row ordering, last flag, bottom row and hold of the composer.
// ----------------------------------------------------------------------------
module trs_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         row_index,
  input logic signed [31:0] col0,
  input logic signed [31:0] col3,
  input logic               last_row
);

  logic [1:0] exp_row;
  always_ff @(posedge clk) begin
    if (rst) exp_row <= '0;
    else if (pop && !empty) exp_row <= exp_row + 1'b1;
  end

  a_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> row_index == exp_row) else $error("row out of order");
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> last_row == (row_index == 2'd3)) else $error("last flag wrong");
  a_row3: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_row) |-> (col0 == 0 && col3 == 32'sd65536))
    else $error("bottom row wrong");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(row_index)))
    else $error("beat dropped");

endmodule

bind euler_trs_matrix_compose_core trs_checker u_trs_checker (
  .clk, .rst, .empty, .pop, .row_index, .col0, .col3, .last_row);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the euler trs matrix composer: items are pushed with
// random gaps, each one is predicted as four row beats (cordic sin/cos, R*S
// rounding and saturation, shift column) and compared with the popped beats.
// ----------------------------------------------------------------------------
module tb_top;
  import trs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] scl [3];
    logic [15:0]        ang [3];
    logic signed [31:0] sft [3];
  } trs_item_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] c [4];
    logic               lst;
  } row_beat_t;

  localparam int NumRandom = 260;
  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [31:0] scale_x = '0, scale_y = '0, scale_z = '0;
  logic [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
  logic signed [31:0] shift_x = '0, shift_y = '0, shift_z = '0;
  logic [1:0] row_index;
  logic signed [31:0] col0, col1, col2, col3;
  logic last_row;

  trs_item_t pending_items[$];
  row_beat_t expected_rows[$];
  int errors = 0;
  int beats_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  bit stim_done = 1'b0;

  always #5 clk = ~clk;

  euler_trs_matrix_compose_core i_dut (.*);

  function automatic longint atan_step(int i);
    longint t [24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
    return t[i];
  endfunction

  function automatic longint q30_to_q16(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  function automatic void cordic_sincos(logic [15:0] a, output longint s, output longint c);
    logic [31:0] z;
    bit flip;
    longint zs, x, y, dx, dy;
    int steps;
    z = {a, 16'h0000};
    flip = (z[31:30] == 2'd1) || (z[31:30] == 2'd2);
    if (flip) z = z - 32'h8000_0000;
    zs = longint'(signed'(z));
    x = 652032874;
    y = 0;
    steps = (CordicSteps > 24) ? 24 : CordicSteps;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (zs >= 0) begin
        x -= dx; y += dy; zs -= atan_step(i);
      end else begin
        x += dx; y -= dy; zs += atan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = q30_to_q16(x);
    s = q30_to_q16(y);
  endfunction

  function automatic void mat_mul(input longint a [3][3], input longint b [3][3],
                                  output longint r [3][3]);
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        r[i][j] = (acc + 32768) >>> 16;
      end
  endfunction

  function automatic void predict_matrix_rows(trs_item_t it);
    longint sx, cx, sy, cy, sz, cz, v;
    longint rx [3][3], ry [3][3], rz [3][3], zy [3][3], rot [3][3];
    row_beat_t b;
    cordic_sincos(it.ang[0], sx, cx);
    cordic_sincos(it.ang[1], sy, cy);
    cordic_sincos(it.ang[2], sz, cz);
    rx = '{'{65536, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
    ry = '{'{cy, 0, -sy}, '{0, 65536, 0}, '{sy, 0, cy}};
    rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, 65536}};
    mat_mul(rz, ry, zy);
    mat_mul(zy, rx, rot);
    for (int r = 0; r < 4; r++) begin
      b.row = r[1:0];
      b.lst = (r == 3);
      if (r < 3) begin
        for (int c = 0; c < 3; c++) begin
          v = (rot[r][c] * longint'(it.scl[c]) + 32768) >>> 16;
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
          b.c[c] = v[31:0];
        end
        b.c[3] = it.sft[r];
      end else begin
        b.c = '{32'sd0, 32'sd0, 32'sd0, 32'sd65536};
      end
      expected_rows.push_back(b);
    end
  endfunction

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic void add_item(trs_item_t it);
    pending_items.push_back(it);
  endfunction

  // stimulus
  initial begin
    trs_item_t it;
    logic [15:0] dir_ang [12] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff,
                                  16'h3fff, 16'h4001, 16'hbfff, 16'hc001, 16'h2000,
                                  16'h7fff, 16'h0001};
    foreach (dir_ang[k]) begin
      it.scl = '{32'sd65536, 32'sd65536, 32'sd65536};
      it.ang = '{dir_ang[k], dir_ang[(k + 3) % 12], dir_ang[(k + 7) % 12]};
      it.sft = '{32'sh7fffffff, 32'sh80000000, 32'sd0};
      add_item(it);
    end
    it.scl = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    it.ang = '{16'h0000, 16'h0000, 16'h0000};
    it.sft = '{32'sh80000000, 32'sh7fffffff, 32'shffffffff};
    add_item(it);
    it.scl = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    it.ang = '{16'h8000, 16'h8000, 16'h8000};
    add_item(it);
    it.scl = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    it.ang = '{16'h2000, 16'h6000, 16'ha000};
    it.sft = '{32'sh0, 32'sh0, 32'sh0};
    add_item(it);
    it.scl = '{32'shffffffff, 32'sh0, 32'sh1};
    it.ang = '{16'hffff, 16'hffff, 16'hffff};
    it.sft = '{32'sh55555555, 32'shaaaaaaaa, 32'sh12345678};
    add_item(it);
    for (int n = 0; n < NumRandom; n++) begin
      foreach (it.scl[c]) begin
        it.scl[c] = rand_q16();
        it.ang[c] = $urandom();
        it.sft[c] = $urandom();
      end
      add_item(it);
    end
  end

  // driver
  int push_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_matrix_rows(pending_items.pop_front());
        items_sent++;
        push_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end
      if ((!push || !full) && push_wait > 0) begin
        push_wait--;
        push <= 1'b0;
      end else if (!push || !full) begin
        if (pending_items.size() > (push && !full ? 0 : 0) &&
            pending_items.size() > 0) begin
          push <= 1'b1;
          {scale_x, scale_y, scale_z} <= {pending_items[0].scl[0], pending_items[0].scl[1],
                                          pending_items[0].scl[2]};
          {angle_x, angle_y, angle_z} <= {pending_items[0].ang[0], pending_items[0].ang[1],
                                          pending_items[0].ang[2]};
          {shift_x, shift_y, shift_z} <= {pending_items[0].sft[0], pending_items[0].sft[1],
                                          pending_items[0].sft[2]};
        end else begin
          push <= 1'b0;
          stim_done = 1'b1;
        end
      end
    end
  end

  // monitor
  int pop_wait = 0;
  always @(posedge clk) begin
    row_beat_t e;
    cycles++;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        beats_seen++;
        if (expected_rows.size() == 0) begin
          $error("unexpected beat row_index=%0d", row_index);
          errors++;
        end else begin
          e = expected_rows.pop_front();
          if (row_index !== e.row) begin
            $error("row_index exp %0d got %0d", e.row, row_index); errors++;
          end
          if (col0 !== e.c[0]) begin
            $error("col0 exp %0d got %0d", e.c[0], col0); errors++;
          end
          if (col1 !== e.c[1]) begin
            $error("col1 exp %0d got %0d", e.c[1], col1); errors++;
          end
          if (col2 !== e.c[2]) begin
            $error("col2 exp %0d got %0d", e.c[2], col2); errors++;
          end
          if (col3 !== e.c[3]) begin
            $error("col3 exp %0d got %0d", e.c[3], col3); errors++;
          end
          if (last_row !== e.lst) begin
            $error("last_row exp %0d got %0d", e.lst, last_row); errors++;
          end
        end
        pop_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && expected_rows.size() == 0) && cycles < CycleLimit)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      $display("%0d items composed, %0d row beats checked, random gaps on both sides",
               items_sent, beats_seen);
      if (errors == 0 && expected_rows.size() == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
      $finish;
    end
  end

endmodule
